// ===== design/hmdp_pkg.sv =====
// Shared types and constants for the HID mouse descriptor parser.
package hmdp_pkg;

  localparam logic [7:0] TAG_USAGE_PAGE = 8'h04;
  localparam logic [7:0] TAG_USAGE      = 8'h08;
  localparam logic [7:0] TAG_USAGE_MIN  = 8'h18;
  localparam logic [7:0] TAG_LOG_MIN    = 8'h14;
  localparam logic [7:0] TAG_LOG_MAX    = 8'h24;
  localparam logic [7:0] TAG_REP_SIZE   = 8'h74;
  localparam logic [7:0] TAG_REP_ID     = 8'h84;
  localparam logic [7:0] TAG_REP_COUNT  = 8'h94;
  localparam logic [7:0] TAG_INPUT      = 8'h80;
  localparam logic [7:0] PAGE_DESKTOP   = 8'h01;
  localparam logic [7:0] PAGE_BUTTON    = 8'h09;
  localparam logic [7:0] USAGE_X        = 8'h30;
  localparam logic [7:0] USAGE_Y        = 8'h31;
  localparam logic [7:0] USAGE_WHEEL    = 8'h38;

  localparam logic [1:0] KIND_BUTTONS = 2'd0;
  localparam logic [1:0] KIND_X       = 2'd1;
  localparam logic [1:0] KIND_Y       = 2'd2;
  localparam logic [1:0] KIND_WHEEL   = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic take_byte;   // absorb in byte into item assembly
    logic scan_start;  // begin Input usage scan
    logic scan_step;   // process one pending usage
    logic scan_end;    // finish Input item
    logic emit_load;   // load output register with kind emit_kind
    logic [1:0] emit_kind;
    logic clear;       // return to reset state
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic item_done;   // byte just taken completed an Input item
    logic scan_more;   // another usage to scan
  } sts_t;

endpackage

// ===== design/hid_mouse_descriptor_parser_top.sv =====
// Top level of the HID mouse descriptor parser.
// Usage:
//   The in channel takes one descriptor byte per word; in_tlast marks the
//   final byte of a descriptor. Short items are decoded as they complete.
//   A byte that completes an Input item holds in_tready low for a usage
//   scan of min(pending usages, report count) usages, one pending usage
//   per cycle, and a closing scan_end step.
//   After the final byte the block sends four layout words on the out
//   channel (buttons, X, Y, wheel), out_tlast on the wheel word. Each word
//   is loaded in S_LOAD and then waits in the output register until taken;
//   a stalled receiver simply holds the block. After the fourth word the
//   S_CLR state clears the parser state and the next descriptor may start.
//   A descriptor lacking X or Y yields the fixed boot mouse layout.
//   rst_n (synchronous, active low) clears the parser to its empty state.
module hid_mouse_descriptor_parser_top
  import hmdp_pkg::*;
#(
  parameter int MAX_PENDING_USAGES = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // desc_byte
  input  logic         in_tlast,   // final_byte
  output logic         out_tvalid,
  input  logic         out_tready,
  // field_kind[1:0], present[2], start_bit[18:3], width_bits[34:19],
  // logical_low[66:35], logical_high[98:67], sign_flag[99], rel_flag[100],
  // report_number[108:101], report_bytes[122:109], boot_layout[123], pad
  output logic [127:0] out_tdata,
  output logic         out_tlast   // last
);
  ctl_t ctl;
  sts_t sts;
  logic [124:0] res;

  hmdp_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_final(in_tlast),
    .in_tready(in_tready), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .sts(sts), .ctl(ctl)
  );

  hmdp_datapath #(.MAX_PENDING_USAGES(MAX_PENDING_USAGES)) u_dp (
    .clk(clk), .byte_i(in_tdata), .ctl(ctl), .sts(sts), .res_o(res)
  );

  assign out_tdata = {4'd0, res[123:0]};
  assign out_tlast = res[124];
endmodule

// ===== design/hmdp_datapath.sv =====
// Datapath: item assembly, global state, usage list, layout table, result word.
module hmdp_datapath
  import hmdp_pkg::*;
#(
  parameter int MAX_PENDING_USAGES = 16
) (
  input  logic        clk,
  input  logic [7:0]  byte_i,
  input  ctl_t        ctl,
  output sts_t        sts,
  output logic [124:0] res_o
);
  localparam int PW = $clog2(MAX_PENDING_USAGES + 1);
  localparam int IW = (MAX_PENDING_USAGES > 1) ? $clog2(MAX_PENDING_USAGES) : 1;

  logic [2:0]  left_r, size_r;
  logic [7:0]  tag_r;
  logic [31:0] val_r;
  logic [7:0]  page_r, fsize_r, fcount_r, rid_r;
  logic [31:0] gmin_r, gmax_r;
  logic [15:0] bitpos_r;
  logic [7:0]  plist_r [MAX_PENDING_USAGES];
  logic [PW-1:0] ptot_r;
  logic [3:0]  found_r;
  logic [15:0] loff_r [4];
  logic [15:0] lwid_r [4];
  logic [31:0] lmin_r [4];
  logic [31:0] lmax_r [4];
  logic [1:0]  lfl_r [4];
  logic [31:0] in_data_r;
  logic [7:0]  sidx_r;
  logic [15:0] soff_r;
  logic [15:0] prod_r;
  logic [124:0] res_r;

  // item assembly
  logic [2:0]  sz;
  logic [31:0] val_new, v;
  logic        done;
  logic [7:0]  tag_c;
  logic [2:0]  size_c;
  always_comb begin
    sz = (byte_i[1:0] == 2'd3) ? 3'd4 : {1'b0, byte_i[1:0]};
    val_new = val_r;
    tag_c = tag_r;
    size_c = size_r;
    done = 1'b0;
    if (left_r == 3'd0) begin
      tag_c = byte_i & 8'hFC;
      size_c = sz;
      val_new = '0;
      done = (sz == 3'd0);
    end else begin
      val_new = val_r | ({24'd0, byte_i} << (5'(size_r - left_r) * 5'd8 & 5'd24));
      done = (left_r == 3'd1);
    end
    v = val_new;
    if (size_c == 3'd1 && v[7]) v[31:8] = '1;
    if (size_c == 3'd2 && v[15]) v[31:16] = '1;
  end

  assign sts.item_done = ctl.take_byte && done && tag_c == TAG_INPUT;
  assign sts.scan_more = sidx_r < 8'(ptot_r) && sidx_r < fcount_r;

  logic [7:0] u;
  assign u = plist_r[sidx_r[IW-1:0]];
  logic [1:0] axfl;
  assign axfl = {in_data_r[2], gmin_r[31]};

  // result word: kind,present,off,wid,min,max,sgn,rel,rid,bytes,boot,last
  logic [124:0] res_c;
  logic boot;
  logic [16:0] rb;
  always_comb begin
    boot = !(found_r[1] && found_r[2]);
    rb = ({1'b0, bitpos_r} + 17'd7) >> 3;
    if (boot) begin
      if (ctl.emit_kind == KIND_BUTTONS)
        res_c = {1'b0, 1'b1, 14'd3, 8'd0, 1'b0, 1'b0, 32'd255, 32'd0,
                 16'd8, 16'd0, 1'b1, ctl.emit_kind};
      else
        res_c = {ctl.emit_kind == KIND_WHEEL, 1'b1, 14'd3, 8'd0, 1'b1, 1'b1,
                 32'd127, 32'hFFFF_FF81, 16'd8, {11'd0, ctl.emit_kind, 3'd0},
                 1'b1, ctl.emit_kind};
    end else begin
      res_c = {ctl.emit_kind == KIND_WHEEL, 1'b0, rb[13:0], rid_r,
               lfl_r[ctl.emit_kind][1], lfl_r[ctl.emit_kind][0],
               lmax_r[ctl.emit_kind], lmin_r[ctl.emit_kind],
               lwid_r[ctl.emit_kind], loff_r[ctl.emit_kind],
               found_r[ctl.emit_kind], ctl.emit_kind};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      left_r <= '0; size_r <= '0; tag_r <= '0; val_r <= '0;
      page_r <= '0; gmin_r <= '0; gmax_r <= '0; fsize_r <= '0;
      fcount_r <= '0; rid_r <= '0; bitpos_r <= '0; ptot_r <= '0;
      found_r <= '0;
      for (int k = 0; k < 4; k++) begin
        loff_r[k] <= '0; lwid_r[k] <= '0; lmin_r[k] <= '0;
        lmax_r[k] <= '0; lfl_r[k] <= '0;
      end
    end else begin
      if (ctl.take_byte) begin
        tag_r <= tag_c; size_r <= size_c; val_r <= val_new;
        left_r <= (left_r == 3'd0) ? sz : left_r - 3'd1;
        if (done) begin
          case (tag_c)
            TAG_USAGE_PAGE: begin page_r <= v[7:0]; ptot_r <= '0; end
            TAG_USAGE: if (ptot_r < PW'(MAX_PENDING_USAGES)) begin
              plist_r[ptot_r[IW-1:0]] <= v[7:0]; ptot_r <= ptot_r + 1'b1;
            end
            TAG_USAGE_MIN: if (page_r == PAGE_BUTTON &&
                               ptot_r < PW'(MAX_PENDING_USAGES)) begin
              plist_r[ptot_r[IW-1:0]] <= 8'd1; ptot_r <= ptot_r + 1'b1;
            end
            TAG_LOG_MIN: gmin_r <= v;
            TAG_LOG_MAX: gmax_r <= v;
            TAG_REP_SIZE: fsize_r <= v[7:0];
            TAG_REP_COUNT: fcount_r <= v[7:0];
            TAG_REP_ID: begin rid_r <= v[7:0]; bitpos_r <= 16'd8; end
            TAG_INPUT: in_data_r <= v;
            default: ;
          endcase
        end
      end
      if (ctl.scan_start) begin
        sidx_r <= '0;
        soff_r <= bitpos_r;
        prod_r <= {8'd0, fsize_r} * {8'd0, fcount_r};
      end
      if (ctl.scan_step) begin
        sidx_r <= sidx_r + 8'd1;
        soff_r <= soff_r + {8'd0, fsize_r};
        if (page_r == PAGE_DESKTOP) begin
          if (u == USAGE_X && !found_r[1]) begin
            loff_r[1] <= soff_r; lwid_r[1] <= {8'd0, fsize_r}; lmin_r[1] <= gmin_r;
            lmax_r[1] <= gmax_r; lfl_r[1] <= axfl; found_r[1] <= 1'b1;
          end else if (u == USAGE_Y && !found_r[2]) begin
            loff_r[2] <= soff_r; lwid_r[2] <= {8'd0, fsize_r}; lmin_r[2] <= gmin_r;
            lmax_r[2] <= gmax_r; lfl_r[2] <= axfl; found_r[2] <= 1'b1;
          end else if (u == USAGE_WHEEL && !found_r[3]) begin
            loff_r[3] <= soff_r; lwid_r[3] <= {8'd0, fsize_r}; lmin_r[3] <= gmin_r;
            lmax_r[3] <= gmax_r; lfl_r[3] <= axfl; found_r[3] <= 1'b1;
          end
        end else if (page_r == PAGE_BUTTON && !found_r[0]) begin
          loff_r[0] <= bitpos_r; lwid_r[0] <= prod_r; lmin_r[0] <= gmin_r;
          lmax_r[0] <= gmax_r; lfl_r[0] <= 2'd0; found_r[0] <= 1'b1;
        end
      end
      if (ctl.scan_end) begin
        ptot_r <= '0;
        bitpos_r <= bitpos_r + prod_r;
      end
    end
    if (ctl.emit_load) res_r <= res_c;
  end

  assign res_o = res_r;
endmodule

// ===== design/hmdp_ctrl.sv =====
// Controller: byte intake, Input usage scan sequencing and result emission.
module hmdp_ctrl
  import hmdp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  input  logic in_final,
  output logic in_tready,
  output logic out_tvalid,
  input  logic out_tready,
  input  sts_t sts,
  output ctl_t ctl
);
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001, S_SCAN = 5'b00010, S_LOAD = 5'b00100,
    S_SEND = 5'b01000, S_CLR = 5'b10000
  } st_t;

  st_t st_r, st_nxt;
  logic fin_r, fin_nxt;
  logic [1:0] k_r, k_nxt;
  logic ov_r, ov_nxt;

  always_comb begin
    st_nxt = st_r; fin_nxt = fin_r; k_nxt = k_r; ov_nxt = ov_r;
    ctl = '0;
    ctl.emit_kind = k_r;
    in_tready = 1'b0;
    case (st_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          ctl.take_byte = 1'b1;
          fin_nxt = in_final;
          k_nxt = KIND_BUTTONS;
          if (sts.item_done) begin
            ctl.scan_start = 1'b1; st_nxt = S_SCAN;
          end else if (in_final) st_nxt = S_LOAD;
        end
      end
      S_SCAN: begin
        if (sts.scan_more) ctl.scan_step = 1'b1;
        else begin
          ctl.scan_end = 1'b1;
          st_nxt = fin_r ? S_LOAD : S_IDLE;
        end
      end
      S_LOAD: begin
        ctl.emit_load = 1'b1; ov_nxt = 1'b1; st_nxt = S_SEND;
      end
      S_SEND: begin
        if (out_tready) begin
          ov_nxt = 1'b0;
          if (k_r == KIND_WHEEL) st_nxt = S_CLR;
          else begin k_nxt = k_r + 2'd1; st_nxt = S_LOAD; end
        end
      end
      S_CLR: begin
        ctl.clear = 1'b1; st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
    if (!rst_n) ctl.clear = 1'b1;
  end
  assign out_tvalid = ov_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; fin_r <= 1'b0; k_r <= '0; ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt; fin_r <= fin_nxt; k_r <= k_nxt; ov_r <= ov_nxt;
    end
  end
endmodule
